@@ rtl/core/bmu16_pkg.sv @@
// bmu16_pkg: shared types and constants of the 16-bit bit-manipulation unit
`default_nettype none
package bmu16_pkg;

	localparam int unsigned DataWidth  = 16;
	localparam int unsigned AmtWidth   = 4;
	localparam int unsigned CountWidth = 6;
	localparam int unsigned ApbWidth   = 32;
	localparam int unsigned AddrWidth  = 3;

	localparam logic [DataWidth-1:0] MaxValueReset = 16'hFFFF;

	typedef logic [DataWidth-1:0]         data_t;
	typedef logic [AmtWidth-1:0]          amt_t;
	typedef logic signed [CountWidth-1:0] count_t;

	// function codes
	typedef enum logic [3:0] {
		FN_ROTL      = 4'd0,
		FN_ROTR      = 4'd1,
		FN_REVERSE   = 4'd2,
		FN_POPCOUNT  = 4'd3,
		FN_PARITY    = 4'd4,
		FN_CLZ       = 4'd5,
		FN_CTZ       = 4'd6,
		FN_HIGHEST   = 4'd7,
		FN_LOWEST    = 4'd8,
		FN_BITLENGTH = 4'd9,
		FN_SET       = 4'd10,
		FN_CLEAR     = 4'd11,
		FN_TOGGLE    = 4'd12,
		FN_TEST      = 4'd13,
		FN_ZERO      = 4'd14,
		FN_ATMAX     = 4'd15
	} func_t;

	// register word indexes
	typedef enum logic [0:0] {
		REG_MAX_VALUE = 1'b0,
		REG_NONE      = 1'b1
	} reg_idx_t;

	localparam count_t CountNone = 6'sh3F;

endpackage
`default_nettype wire

@@ rtl/core/bmu16_if.sv @@
// bmu16_if: valid/ready channels for command and result items
`default_nettype none
interface bmu16_cmd_if;
	logic                valid;
	logic                ready;
	bmu16_pkg::func_t    func;
	bmu16_pkg::data_t    operand;
	bmu16_pkg::amt_t     amount;

	modport source (output valid, output func, output operand, output amount, input ready);
	modport sink   (input valid, input func, input operand, input amount, output ready);
endinterface

interface bmu16_res_if;
	logic                valid;
	logic                ready;
	bmu16_pkg::data_t    result_value;
	bmu16_pkg::count_t   result_count;
	logic                result_flag;

	modport source (output valid, output result_value, output result_count,
		output result_flag, input ready);
	modport sink   (input valid, input result_value, input result_count,
		input result_flag, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bit_manipulation_unit_16.sv @@
// bit_manipulation_unit_16: two-register bit-manipulation unit with apb config
// datapath: an accepted item is held in the input register, then moves to the result register once that is free
// throughput: one item per cycle; the input register and result register each
// stall only when the result register is full and not taken
// reset: arst_n clears both valid bits and sets max_value to 0xFFFF
`default_nettype none
module bit_manipulation_unit_16 (
	input  wire                             clk,
	input  wire                             arst_n,
	bmu16_cmd_if.sink                       cmd,
	bmu16_res_if.source                     res,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire [bmu16_pkg::AddrWidth-1:0]  paddr,
	input  wire [bmu16_pkg::ApbWidth-1:0]   pwdata,
	output logic [bmu16_pkg::ApbWidth-1:0]  prdata,
	output logic                            pready
);
	import bmu16_pkg::*;

	// configuration
	data_t    max_value_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	assign reg_idx = reg_idx_t'(paddr[AddrWidth-1]);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= MaxValueReset;
		end else if (cfg_wr && reg_idx == REG_MAX_VALUE) begin
			max_value_q <= pwdata[DataWidth-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAX_VALUE: prdata = {{(ApbWidth-DataWidth){1'b0}}, max_value_q};
			default:       prdata = '0;
		endcase
	end

	// stage 1: input register
	logic  valid_s1;
	func_t func_s1;
	data_t operand_s1;
	amt_t  amount_s1;
	logic  free_s2;
	logic  adv_s1;

	assign free_s2   = !res.valid || res.ready;
	assign adv_s1    = valid_s1 && free_s2;
	assign cmd.ready = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1    <= cmd.func;
			operand_s1 <= cmd.operand;
			amount_s1  <= cmd.amount;
		end
	end

	// bit-index search in four halving steps
	logic [3:0]           msb_idx;
	logic [3:0]           lsb_idx;
	logic [7:0]           hi8, lo8;
	logic [3:0]           hi4, lo4;
	logic [1:0]           hi2, lo2;
	logic                 is_zero;
	logic [4:0]           bit_len;
	logic [4:0]           pop;
	logic [2:0]           nib_cnt [4];
	logic [2*DataWidth-1:0] rotl_w, rotr_w;
	data_t                rev;
	data_t                bit_mask;

	always_comb begin
		is_zero    = (operand_s1 == '0);

		msb_idx[3] = |operand_s1[15:8];
		hi8        = msb_idx[3] ? operand_s1[15:8] : operand_s1[7:0];
		msb_idx[2] = |hi8[7:4];
		hi4        = msb_idx[2] ? hi8[7:4] : hi8[3:0];
		msb_idx[1] = |hi4[3:2];
		hi2        = msb_idx[1] ? hi4[3:2] : hi4[1:0];
		msb_idx[0] = hi2[1];

		lsb_idx[3] = ~|operand_s1[7:0];
		lo8        = lsb_idx[3] ? operand_s1[15:8] : operand_s1[7:0];
		lsb_idx[2] = ~|lo8[3:0];
		lo4        = lsb_idx[2] ? lo8[7:4] : lo8[3:0];
		lsb_idx[1] = ~|lo4[1:0];
		lo2        = lsb_idx[1] ? lo4[3:2] : lo4[1:0];
		lsb_idx[0] = ~lo2[0];

		bit_len = is_zero ? 5'd0 : {1'b0, msb_idx} + 5'd1;

		for (int n = 0; n < 4; n++) begin
			nib_cnt[n] = 3'({2'b0, operand_s1[4*n]}) + 3'({2'b0, operand_s1[4*n+1]})
				+ 3'({2'b0, operand_s1[4*n+2]}) + 3'({2'b0, operand_s1[4*n+3]});
		end
		pop = (5'(nib_cnt[0]) + 5'(nib_cnt[1])) + (5'(nib_cnt[2]) + 5'(nib_cnt[3]));

		for (int b = 0; b < DataWidth; b++) begin
			rev[b] = operand_s1[DataWidth-1-b];
		end

		rotl_w   = {operand_s1, operand_s1} << amount_s1;
		rotr_w   = {operand_s1, operand_s1} >> amount_s1;
		bit_mask = data_t'(1) << amount_s1;
	end

	data_t  value_c;
	count_t count_c;
	logic   flag_c;

	always_comb begin
		value_c = operand_s1;
		count_c = '0;
		flag_c  = 1'b0;
		unique case (func_s1)
			FN_ROTL:      value_c = rotl_w[2*DataWidth-1:DataWidth];
			FN_ROTR:      value_c = rotr_w[DataWidth-1:0];
			FN_REVERSE:   value_c = rev;
			FN_POPCOUNT:  count_c = count_t'({1'b0, pop});
			FN_PARITY:    flag_c  = ~^operand_s1;
			FN_CLZ:       count_c = count_t'(6'd16 - {1'b0, bit_len});
			FN_CTZ:       count_c = is_zero ? count_t'(6'd16) : count_t'({2'b0, lsb_idx});
			FN_HIGHEST:   count_c = is_zero ? CountNone : count_t'({2'b0, msb_idx});
			FN_LOWEST:    count_c = is_zero ? CountNone : count_t'({2'b0, lsb_idx});
			FN_BITLENGTH: count_c = count_t'({1'b0, bit_len});
			FN_SET:       value_c = operand_s1 | bit_mask;
			FN_CLEAR:     value_c = operand_s1 & ~bit_mask;
			FN_TOGGLE:    value_c = operand_s1 ^ bit_mask;
			FN_TEST:      flag_c  = |(operand_s1 & bit_mask);
			FN_ZERO:      flag_c  = is_zero;
			FN_ATMAX:     flag_c  = (operand_s1 >= max_value_q);
			default:      flag_c  = 1'b0;
		endcase
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (free_s2) begin
			res.valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res.result_value <= value_c;
			res.result_count <= count_c;
			res.result_flag  <= flag_c;
		end
	end

	// a taken result always leaves room for a new item
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		res.ready |-> cmd.ready)
		else $error("cmd not ready although result side is draining");

	// an item held in the input register is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !free_s2 |=> valid_s1)
		else $error("item lost from input register");

	// a new result only appears from an item in the input register
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(valid_s1))
		else $error("result appeared without an item");

	// threshold write lands
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && reg_idx == REG_MAX_VALUE |=> max_value_q == $past(pwdata[DataWidth-1:0]))
		else $error("max_value write not taken");

endmodule
`default_nettype wire

@@ tb/tb_bit_manipulation_unit_16.sv @@
// testbench for the 16-bit bit-manipulation unit: directed and random items, apb threshold writes
`timescale 1ns / 100ps
module tb_bit_manipulation_unit_16;
	import bmu16_pkg::*;

	localparam int CycleLimit = 200000;

	typedef struct packed {
		data_t  value;
		count_t count;
		logic   flag;
	} bmu_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 rx_ready = 1'b0;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [ApbWidth-1:0]  pwdata;
	logic [ApbWidth-1:0]  prdata;
	logic                 pready;

	bmu16_cmd_if cmd_ch ();
	bmu16_res_if res_ch ();

	assign res_ch.ready = rx_ready;

	bmu_out_t pending_results[$];
	data_t    max_limit = MaxValueReset;
	bit       idle_on = 1'b1;
	int       stall_left = 0;
	int       mismatch_count = 0;
	int       cycle_count = 0;

	bit_manipulation_unit_16 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("tb_bit_manipulation_unit_16 NOT OK");
			$finish;
		end
	end

	function automatic bmu_out_t predict_result(input func_t fn, input data_t op,
		input amt_t amt, input data_t thr);
		bmu_out_t r;
		logic [31:0] pair;
		int ones;
		int len;
		int tz;
		r.value = op;
		r.count = '0;
		r.flag = 1'b0;
		pair = {op, op};
		ones = 0;
		len = 0;
		tz = 16;
		for (int i = 0; i < 16; i++) begin
			if (op[i]) begin
				ones++;
				len = i + 1;
				if (tz == 16)
					tz = i;
			end
		end
		case (fn)
			FN_ROTL: begin
				pair = pair << amt;
				r.value = pair[31:16];
			end
			FN_ROTR: begin
				pair = pair >> amt;
				r.value = pair[15:0];
			end
			FN_REVERSE:   for (int i = 0; i < 16; i++) r.value[i] = op[15-i];
			FN_POPCOUNT:  r.count = count_t'(ones);
			FN_PARITY:    r.flag = ~ones[0];
			FN_CLZ:       r.count = count_t'(16 - len);
			FN_CTZ:       r.count = count_t'(tz);
			// zero operand wraps to -1
			FN_HIGHEST:   r.count = count_t'(len - 1);
			FN_LOWEST:    r.count = (op == '0) ? count_t'(-1) : count_t'(tz);
			FN_BITLENGTH: r.count = count_t'(len);
			FN_SET:       r.value = op | (data_t'(1) << amt);
			FN_CLEAR:     r.value = op & ~(data_t'(1) << amt);
			FN_TOGGLE:    r.value = op ^ (data_t'(1) << amt);
			FN_TEST:      r.flag = op[amt];
			FN_ZERO:      r.flag = (op == '0);
			default:      r.flag = (op >= thr);
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch: %s", what);
	endtask

	// result sink with random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rx_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			rx_ready <= 1'b0;
			stall_left <= $urandom_range(0, 13);
		end else begin
			rx_ready <= 1'b1;
		end
	end

	// results are checked before the item taken at the same edge is predicted
	always @(posedge clk) begin
		bmu_out_t want;
		if (arst_n) begin
			if (res_ch.valid && rx_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %h count %h flag %b",
						res_ch.result_value, res_ch.result_count, res_ch.result_flag));
				end else begin
					want = pending_results.pop_front();
					if (res_ch.result_value !== want.value || res_ch.result_count !== want.count
						|| res_ch.result_flag !== want.flag)
						report_mismatch($sformatf(
							"expected value %h count %h flag %b, got value %h count %h flag %b",
							want.value, want.count, want.flag, res_ch.result_value,
							res_ch.result_count, res_ch.result_flag));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				pending_results.push_back(predict_result(cmd_ch.func, cmd_ch.operand,
					cmd_ch.amount, max_limit));
		end
	end

	task automatic send_item(input func_t fn, input data_t op, input amt_t amt);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= fn;
		cmd_ch.operand <= op;
		cmd_ch.amount <= amt;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// stop sending and let the unit empty out before touching a register
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [ApbWidth-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrWidth'(4 * int'(idx));
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MAX_VALUE)
			max_limit = data[DataWidth-1:0];
		// leave the bus idle before the next transfer
		@(posedge clk);
	endtask

	task automatic check_max_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= AddrWidth'(4 * int'(REG_MAX_VALUE));
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[DataWidth-1:0] !== max_limit)
			report_mismatch($sformatf("max_value read expected %h, got %h", max_limit,
				prdata[DataWidth-1:0]));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic data_t pick_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return data_t'(1) << $urandom_range(0, 15);
			3: return ~(data_t'(1) << $urandom_range(0, 15));
			// straddle the threshold for the compare
			4: return max_limit + data_t'($urandom_range(0, 2)) - data_t'(1);
			default: return data_t'($urandom());
		endcase
	endfunction

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			send_item(func_t'($urandom_range(0, 15)), pick_operand(),
				amt_t'($urandom_range(0, 15)));
	endtask

	task automatic test_reset_state();
		check_max_readback();
		send_item(FN_ATMAX, 16'hFFFF, 4'd0);
		send_item(FN_ATMAX, 16'hFFFE, 4'd0);
		drain();
	endtask

	task automatic test_directed_ops();
		send_item(FN_ROTL, 16'h8001, 4'd0);
		send_item(FN_ROTL, 16'h8001, 4'd15);
		send_item(FN_ROTR, 16'h8001, 4'd0);
		send_item(FN_ROTR, 16'h8001, 4'd15);
		send_item(FN_REVERSE, 16'h0001, 4'd0);
		send_item(FN_POPCOUNT, 16'hFFFF, 4'd0);
		send_item(FN_PARITY, 16'h0000, 4'd0);
		send_item(FN_PARITY, 16'h0001, 4'd0);
		// zero operand: clz and ctz give 16, indexes give -1, bit length gives 0
		send_item(FN_CLZ, 16'h0000, 4'd0);
		send_item(FN_CTZ, 16'h0000, 4'd0);
		send_item(FN_HIGHEST, 16'h0000, 4'd0);
		send_item(FN_LOWEST, 16'h0000, 4'd0);
		send_item(FN_BITLENGTH, 16'h0000, 4'd0);
		send_item(FN_HIGHEST, 16'h8000, 4'd0);
		send_item(FN_CTZ, 16'h8000, 4'd0);
		send_item(FN_SET, 16'h7FFF, 4'd15);
		send_item(FN_CLEAR, 16'hFFFF, 4'd15);
		send_item(FN_TOGGLE, 16'h0000, 4'd0);
		send_item(FN_TEST, 16'h7FFF, 4'd15);
		send_item(FN_ZERO, 16'h0000, 4'd0);
		send_item(FN_ZERO, 16'hFFFF, 4'd0);
		drain();
	endtask

	task automatic test_threshold_extremes();
		apb_write(REG_MAX_VALUE, 32'h0000_0000);
		check_max_readback();
		send_item(FN_ATMAX, 16'h0000, 4'd0);
		run_random(150);
		drain();
		apb_write(REG_MAX_VALUE, 32'h0000_FFFF);
		check_max_readback();
		send_item(FN_ATMAX, 16'hFFFE, 4'd0);
		run_random(150);
		drain();
	endtask

	// a write past the register list must leave the threshold alone
	task automatic test_unmapped_register();
		apb_write(REG_MAX_VALUE, 32'h0000_1234);
		apb_write(REG_NONE, 32'h0000_0001);
		check_max_readback();
		send_item(FN_ATMAX, 16'h1233, 4'd0);
		send_item(FN_ATMAX, 16'h1234, 4'd0);
		drain();
	endtask

	task automatic test_random_thresholds();
		for (int k = 0; k < 3; k++) begin
			apb_write(REG_MAX_VALUE, $urandom());
			check_max_readback();
			run_random(150);
			drain();
		end
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		apb_write(REG_MAX_VALUE, $urandom());
		run_random(200);
		drain();
	endtask

	initial begin
		cmd_ch.valid <= 1'b0;
		cmd_ch.func <= FN_ROTL;
		cmd_ch.operand <= '0;
		cmd_ch.amount <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_ops();
		test_threshold_extremes();
		test_unmapped_register();
		test_random_thresholds();
		test_back_to_back();
		repeat (4) @(posedge clk);
		while (pending_results.size() != 0) begin
			report_mismatch("expected result never arrived");
			void'(pending_results.pop_front());
		end
		if (mismatch_count == 0)
			$display("tb_bit_manipulation_unit_16 OK");
		else
			$display("tb_bit_manipulation_unit_16 NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/bmu16_pkg.sv
rtl/core/bmu16_if.sv
rtl/core/bit_manipulation_unit_16.sv
tb/tb_bit_manipulation_unit_16.sv
